// File: hdl/tcc_pkg.sv
// Shared types, codes and the control program of the text console cursor unit.
`timescale 1ns / 1ps
package tcc_pkg;

    // Character codes handled as controls
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Result action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_DRAW  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ROW_FULL    = 3'd1;
    localparam logic [2:0] ST_COL_FULL    = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_SKIPPED     = 3'd4;

    // Field widths
    localparam int FW_W    = 6;
    localparam int FH_W    = 7;
    localparam int DIM_W   = 10;
    localparam int CHAR_W  = 8;
    localparam int TAB_W   = 5;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 3;
    localparam int OFF_W   = 16;
    localparam int OUTC_W  = 10;
    localparam int CNT_W   = 12;
    localparam int REM_W   = FW_W + 1;
    localparam int OUT_TDATA_W = 56;
    localparam logic [CNT_W-1:0] COUNT_MAX = 12'hFFF;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_FONT_WIDTH     = 3'd0,
        REG_FONT_HEIGHT    = 3'd1,
        REG_DISPLAY_WIDTH  = 3'd2,
        REG_DISPLAY_HEIGHT = 3'd3,
        REG_FIRST_CHAR     = 3'd4,
        REG_LAST_CHAR      = 3'd5,
        REG_TAB_SIZE       = 3'd6
    } t_reg_idx;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_SKIP      = 4'd2,
        OP_FF        = 4'd3,
        OP_CR        = 4'd4,
        OP_LF        = 4'd5,
        OP_UNSUP     = 4'd6,
        OP_DIV1_INIT = 4'd7,
        OP_DIV_STEP  = 4'd8,
        OP_DIV2_INIT = 4'd9,
        OP_TAB_MUL   = 4'd10,
        OP_TAB_END   = 4'd11,
        OP_DRAW_MUL1 = 4'd12,
        OP_DRAW_MUL2 = 4'd13,
        OP_DRAW_END  = 4'd14,
        OP_EMIT      = 4'd15
    } t_op;

    // Next-step selection
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_ACCEPT   = 3'd2,
        C_DISPATCH = 3'd3,
        C_DIV      = 3'd4,
        C_OUT      = 3'd5
    } t_cond;

    // Kind of the byte being handled
    typedef enum logic [2:0] {
        CLS_SKIP  = 3'd0,
        CLS_FF    = 3'd1,
        CLS_CR    = 3'd2,
        CLS_LF    = 3'd3,
        CLS_TAB   = 3'd4,
        CLS_DRAW  = 3'd5,
        CLS_UNSUP = 3'd6
    } t_class;

    localparam int STEP_W = 5;

    // Program addresses
    localparam logic [STEP_W-1:0] A_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] A_DISP  = 5'd1;
    localparam logic [STEP_W-1:0] A_SKIP  = 5'd2;
    localparam logic [STEP_W-1:0] A_FF    = 5'd3;
    localparam logic [STEP_W-1:0] A_CR    = 5'd4;
    localparam logic [STEP_W-1:0] A_LF    = 5'd5;
    localparam logic [STEP_W-1:0] A_UNSUP = 5'd6;
    localparam logic [STEP_W-1:0] A_TAB0  = 5'd7;
    localparam logic [STEP_W-1:0] A_TAB1  = 5'd8;
    localparam logic [STEP_W-1:0] A_TAB2  = 5'd9;
    localparam logic [STEP_W-1:0] A_TAB3  = 5'd10;
    localparam logic [STEP_W-1:0] A_TAB4  = 5'd11;
    localparam logic [STEP_W-1:0] A_TAB5  = 5'd12;
    localparam logic [STEP_W-1:0] A_DRAW0 = 5'd13;
    localparam logic [STEP_W-1:0] A_DRAW1 = 5'd14;
    localparam logic [STEP_W-1:0] A_DRAW2 = 5'd15;
    localparam logic [STEP_W-1:0] A_EMIT  = 5'd16;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
    } t_uword;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic   accept;
        logic   div_last;
        logic   out_free;
        t_class cls;
    } t_seq_flags;

    // Control store
    function automatic t_uword uprog(input logic [STEP_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NOP, cond: C_JUMP, target: A_IDLE};
        case (addr)
            A_IDLE:  w = '{op: OP_LOAD,      cond: C_ACCEPT,   target: A_DISP};
            A_DISP:  w = '{op: OP_NOP,       cond: C_DISPATCH, target: A_IDLE};
            A_SKIP:  w = '{op: OP_SKIP,      cond: C_JUMP,     target: A_EMIT};
            A_FF:    w = '{op: OP_FF,        cond: C_JUMP,     target: A_EMIT};
            A_CR:    w = '{op: OP_CR,        cond: C_JUMP,     target: A_EMIT};
            A_LF:    w = '{op: OP_LF,        cond: C_JUMP,     target: A_EMIT};
            A_UNSUP: w = '{op: OP_UNSUP,     cond: C_JUMP,     target: A_EMIT};
            A_TAB0:  w = '{op: OP_DIV1_INIT, cond: C_NEXT,     target: A_IDLE};
            A_TAB1:  w = '{op: OP_DIV_STEP,  cond: C_DIV,      target: A_IDLE};
            A_TAB2:  w = '{op: OP_DIV2_INIT, cond: C_NEXT,     target: A_IDLE};
            A_TAB3:  w = '{op: OP_DIV_STEP,  cond: C_DIV,      target: A_IDLE};
            A_TAB4:  w = '{op: OP_TAB_MUL,   cond: C_NEXT,     target: A_IDLE};
            A_TAB5:  w = '{op: OP_TAB_END,   cond: C_JUMP,     target: A_EMIT};
            A_DRAW0: w = '{op: OP_DRAW_MUL1, cond: C_NEXT,     target: A_IDLE};
            A_DRAW1: w = '{op: OP_DRAW_MUL2, cond: C_NEXT,     target: A_IDLE};
            A_DRAW2: w = '{op: OP_DRAW_END,  cond: C_NEXT,     target: A_IDLE};
            A_EMIT:  w = '{op: OP_EMIT,      cond: C_OUT,      target: A_IDLE};
            default: w = '{op: OP_NOP,       cond: C_JUMP,     target: A_IDLE};
        endcase
        return w;
    endfunction

    // Dispatch table: byte kind to first step of its routine
    function automatic logic [STEP_W-1:0] class_target(input t_class cls);
        logic [STEP_W-1:0] a;
        a = A_UNSUP;
        unique case (cls)
            CLS_SKIP:  a = A_SKIP;
            CLS_FF:    a = A_FF;
            CLS_CR:    a = A_CR;
            CLS_LF:    a = A_LF;
            CLS_TAB:   a = A_TAB0;
            CLS_DRAW:  a = A_DRAW0;
            CLS_UNSUP: a = A_UNSUP;
            default:   a = A_UNSUP;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/tcc_seq.sv
// Microcode sequencer: step counter, control store read and jump logic.
`timescale 1ns / 1ps
module tcc_seq
    import tcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_seq_flags i_flags,
    output t_uword     o_uword
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uw;

    assign w_uw    = uprog(r_step);
    assign o_uword = w_uw;

    // Next step selection
    always_comb begin
        n_step = r_step;
        unique case (w_uw.cond)
            C_NEXT:     n_step = r_step + 1'b1;
            C_JUMP:     n_step = w_uw.target;
            C_ACCEPT:   n_step = i_flags.accept ? w_uw.target : r_step;
            C_DISPATCH: n_step = class_target(i_flags.cls);
            C_DIV:      n_step = i_flags.div_last ? r_step + 1'b1 : r_step;
            C_OUT:      n_step = i_flags.out_free ? w_uw.target : r_step;
            default:    n_step = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= A_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: hdl/text_console_cursor_unit.sv
// Top level of the text console cursor unit: config registers, datapath, output register.
// A byte is accepted, dispatched by kind, handled by its routine and its result emitted.
//   A tab runs two bit-serial divisions, of the column by the font width and then of the
//   quotient by the tab size, one quotient bit a cycle. The microcode program handles one
//   byte at a time: no new byte is taken until the last result enters the output register.
// Reset (synchronous, active low) homes the cursor, clears the write state, loads
//   register defaults and empties the output register.
`timescale 1ns / 1ps
module text_console_cursor_unit
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Config write port
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] char_code
    input  logic                   s_axis_tlast,   // last_in_write
    // Output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] action, [17:2] glyph_offset, [27:18] draw_column, [37:28] draw_row,
    // [40:38] status, [52:41] bytes_written, [55:53] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 2;
    localparam int CW = $clog2(COORD_BITS + 1);

    // Configuration registers
    logic [FW_W-1:0]   r_fw;
    logic [FH_W-1:0]   r_fh;
    logic [DIM_W-1:0]  r_dw;
    logic [DIM_W-1:0]  r_dh;
    logic [CHAR_W-1:0] r_first;
    logic [CHAR_W-1:0] r_lastc;
    logic [TAB_W-1:0]  r_tab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= 6'd8;
            r_fh    <= 7'd8;
            r_dw    <= 10'd128;
            r_dh    <= 10'd64;
            r_first <= 8'd32;
            r_lastc <= 8'd126;
            r_tab   <= 5'd4;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FONT_WIDTH:     r_fw    <= FW_W'(i_cfg_data);
                REG_FONT_HEIGHT:    r_fh    <= FH_W'(i_cfg_data);
                REG_DISPLAY_WIDTH:  r_dw    <= DIM_W'(i_cfg_data);
                REG_DISPLAY_HEIGHT: r_dh    <= DIM_W'(i_cfg_data);
                REG_FIRST_CHAR:     r_first <= CHAR_W'(i_cfg_data);
                REG_LAST_CHAR:      r_lastc <= CHAR_W'(i_cfg_data);
                REG_TAB_SIZE:       r_tab   <= TAB_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer
    t_uword     w_uw;
    t_seq_flags w_flags;

    tcc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uw)
    );

    // Datapath registers
    logic [CHAR_W-1:0]     r_code;
    logic                  r_last;
    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic                  r_stopped;
    logic [CNT_W-1:0]      r_wcount;
    logic [1:0]            r_act;
    logic [OFF_W-1:0]      r_off;
    logic [OUTC_W-1:0]     r_dcol;
    logic [OUTC_W-1:0]     r_drow;
    logic [2:0]            r_stat;
    logic [OFF_W-1:0]      r_prod;
    logic [COORD_BITS-1:0] r_div_quo;
    logic [REM_W-1:0]      r_div_rem;
    logic [FW_W-1:0]       r_div_dvs;
    logic [CW-1:0]         r_div_cnt;
    logic                  r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic                  w_accept;
    logic                  w_out_free;
    t_class                w_cls;
    logic [REM_W-1:0]      w_rem_sh;
    logic                  w_rem_ge;
    logic [TAB_W-1:0]      w_indent;
    logic                  w_lf_ok;
    logic                  w_tab_ok;
    logic                  w_draw_ok;
    logic [CNT_W-1:0]      w_cnt_after;
    logic [2*FW_W+CHAR_W-1:0] w_mul1;

    assign s_axis_tready = (w_uw.op == OP_LOAD);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Byte classification: skipped while stopped, then controls before the font range
    always_comb begin
        if (r_stopped)                              w_cls = CLS_SKIP;
        else if (r_code == CH_FF)                   w_cls = CLS_FF;
        else if (r_code == CH_CR)                   w_cls = CLS_CR;
        else if (r_code == CH_LF)                   w_cls = CLS_LF;
        else if (r_code == CH_TAB)                  w_cls = CLS_TAB;
        else if (r_code >= r_first && r_code <= r_lastc) w_cls = CLS_DRAW;
        else                                        w_cls = CLS_UNSUP;
    end

    assign w_flags = '{accept: w_accept, div_last: (r_div_cnt == CW'(1)),
                       out_free: w_out_free, cls: w_cls};

    // Restoring divider step
    assign w_rem_sh = {r_div_rem[REM_W-2:0], r_div_quo[COORD_BITS-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_div_dvs});

    // Room checks
    assign w_lf_ok   = (SW'(r_row) + SW'({r_fh, 1'b0})) <= SW'(r_dh);
    assign w_tab_ok  = (SW'(r_col) + SW'(r_prod) + SW'(r_fw)) <= SW'(r_dw);
    assign w_draw_ok = (SW'(r_col) + SW'({r_fw, 1'b0})) <= SW'(r_dw);
    assign w_indent  = (r_tab == '0) ? '0 : r_tab - TAB_W'(r_div_rem);
    assign w_mul1    = (r_code - r_first) * r_fw;

    // Byte count after this byte, saturating; skipped bytes leave it alone
    assign w_cnt_after = r_stopped ? r_wcount
                       : ((r_wcount == COUNT_MAX) ? r_wcount : r_wcount + 1'b1);

    // Datapath control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_stopped <= 1'b0;
            r_wcount  <= '0;
            r_m_valid <= 1'b0;
            r_div_cnt <= '0;
        end else begin
            // output beat taken and no new result loaded this cycle
            if (r_m_valid && m_axis_tready && !(w_uw.op == OP_EMIT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (w_uw.op)
                OP_NOP: ;
                OP_LOAD: begin
                    if (w_accept) begin
                        r_code <= s_axis_tdata;
                        r_last <= s_axis_tlast;
                        r_act  <= ACT_NONE;
                        r_off  <= '0;
                        r_dcol <= '0;
                        r_drow <= '0;
                        r_stat <= ST_OK;
                    end
                end
                OP_SKIP:  r_stat <= ST_SKIPPED;
                OP_FF: begin
                    r_act <= ACT_CLEAR;
                    r_col <= '0;
                    r_row <= '0;
                end
                OP_CR:    r_col <= '0;
                OP_LF: begin
                    if (w_lf_ok) r_row <= COORD_BITS'(SW'(r_row) + SW'(r_fh));
                    else         r_stat <= ST_ROW_FULL;
                end
                OP_UNSUP: r_stat <= ST_UNSUPPORTED;
                OP_DIV1_INIT: begin
                    r_div_quo <= r_col;
                    r_div_dvs <= r_fw;
                    r_div_rem <= '0;
                    r_div_cnt <= CW'(COORD_BITS);
                end
                OP_DIV_STEP: begin
                    r_div_rem <= w_rem_ge ? w_rem_sh - {1'b0, r_div_dvs} : w_rem_sh;
                    r_div_quo <= {r_div_quo[COORD_BITS-2:0], w_rem_ge};
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                OP_DIV2_INIT: begin
                    // zero font width gives a zero quotient
                    r_div_quo <= (r_fw == '0) ? '0 : r_div_quo;
                    r_div_dvs <= FW_W'(r_tab);
                    r_div_rem <= '0;
                    r_div_cnt <= CW'(COORD_BITS);
                end
                OP_TAB_MUL: r_prod <= OFF_W'(w_indent * r_fw);
                OP_TAB_END: begin
                    if (w_tab_ok) r_col <= COORD_BITS'(SW'(r_col) + SW'(r_prod));
                    else          r_stat <= ST_COL_FULL;
                end
                OP_DRAW_MUL1: r_prod <= OFF_W'(w_mul1);
                OP_DRAW_MUL2: r_off  <= OFF_W'(r_prod * r_fh[FH_W-1:3]);
                OP_DRAW_END: begin
                    if (w_draw_ok) begin
                        r_act  <= ACT_DRAW;
                        r_dcol <= OUTC_W'(r_col);
                        r_drow <= OUTC_W'(r_row);
                        r_col  <= COORD_BITS'(SW'(r_col) + SW'(r_fw));
                    end else begin
                        r_off  <= '0;
                        r_stat <= ST_ROW_FULL;
                    end
                end
                OP_EMIT: begin
                    // hold the beat until the output register frees up
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {3'b000, w_cnt_after, r_stat, r_drow, r_dcol,
                                      r_off, r_act};
                        r_wcount  <= r_last ? '0 : w_cnt_after;
                        r_stopped <= r_last ? 1'b0 : (r_stopped | (r_stat != ST_OK));
                    end else begin
                        r_m_valid <= r_m_valid;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: tb/text_console_cursor_unit_test.sv
// Self-checking testbench for the text console cursor unit: predictor, stimulus and checks.
`timescale 1ns / 1ps
module text_console_cursor_unit_test;
    import tcc_pkg::*;

    localparam int COORD_BITS  = 10;
    localparam int STUCK_LIMIT = 2000;   // cycles without any beat before giving up
    localparam int LONG_BYTES  = 150;    // one long write of carriage returns

    // Expected content of one result beat
    typedef struct {
        logic [1:0]        action;
        logic [OFF_W-1:0]  glyph_offset;
        logic [OUTC_W-1:0] draw_column;
        logic [OUTC_W-1:0] draw_row;
        logic [2:0]        status;
        logic [CNT_W-1:0]  bytes_written;
    } cursor_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [IDX_W-1:0]       i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] char_code
    logic                   s_axis_tlast;   // last_in_write
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [1:0] action, [17:2] glyph_offset, [27:18] draw_column, [37:28] draw_row,
    // [40:38] status, [52:41] bytes_written, [55:53] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor copy of the registers and the cursor state
    logic [CFG_W-1:0]      cfg_regs [7];
    logic [COORD_BITS-1:0] cur_col;
    logic [COORD_BITS-1:0] cur_row;
    logic                  write_held;
    logic [CNT_W-1:0]      byte_count;

    cursor_result_t cursor_results_due[$];

    bit full_rate = 1'b0;
    int stall_left = 0;
    int stuck_cycles = 0;
    int fail_count = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int draws_seen = 0;
    int errors_seen = 0;
    int settings_used = 0;

    text_console_cursor_unit #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [CFG_W-1:0] reg_mask(input t_reg_idx idx);
        case (idx)
            REG_FONT_WIDTH:  return CFG_W'((1 << FW_W) - 1);
            REG_FONT_HEIGHT: return CFG_W'((1 << FH_W) - 1);
            REG_FIRST_CHAR,
            REG_LAST_CHAR:   return CFG_W'((1 << CHAR_W) - 1);
            REG_TAB_SIZE:    return CFG_W'((1 << TAB_W) - 1);
            default:         return CFG_W'((1 << DIM_W) - 1);
        endcase
    endfunction

    function automatic void reset_console();
        cfg_regs[REG_FONT_WIDTH]     = 8;
        cfg_regs[REG_FONT_HEIGHT]    = 8;
        cfg_regs[REG_DISPLAY_WIDTH]  = 128;
        cfg_regs[REG_DISPLAY_HEIGHT] = 64;
        cfg_regs[REG_FIRST_CHAR]     = 32;
        cfg_regs[REG_LAST_CHAR]      = 126;
        cfg_regs[REG_TAB_SIZE]       = 4;
        cur_col    = '0;
        cur_row    = '0;
        write_held = 1'b0;
        byte_count = '0;
    endfunction

    // Cursor update for one byte; returns the result beat it causes
    function automatic cursor_result_t console_step(input logic [7:0] code, input logic is_last);
        cursor_result_t r;
        int unsigned fw, fh, dw, dh, lo, hi, ts, col, row, q, indent;
        fw  = cfg_regs[REG_FONT_WIDTH];
        fh  = cfg_regs[REG_FONT_HEIGHT];
        dw  = cfg_regs[REG_DISPLAY_WIDTH];
        dh  = cfg_regs[REG_DISPLAY_HEIGHT];
        lo  = cfg_regs[REG_FIRST_CHAR];
        hi  = cfg_regs[REG_LAST_CHAR];
        ts  = cfg_regs[REG_TAB_SIZE];
        col = cur_col;
        row = cur_row;
        r.action        = ACT_NONE;
        r.glyph_offset  = '0;
        r.draw_column   = '0;
        r.draw_row      = '0;
        r.status        = ST_OK;
        if (write_held) begin
            r.status = ST_SKIPPED;
        end else begin
            // controls win over the font range
            if (code == CH_FF) begin
                r.action = ACT_CLEAR;
                cur_col  = '0;
                cur_row  = '0;
            end else if (code == CH_CR) begin
                cur_col = '0;
            end else if (code == CH_LF) begin
                if (row + 2 * fh <= dh) cur_row = COORD_BITS'(row + fh);
                else r.status = ST_ROW_FULL;
            end else if (code == CH_TAB) begin
                q      = (fw != 0) ? col / fw : 0;
                indent = (ts != 0) ? ts - (q % ts) : 0;
                if (col + indent * fw + fw <= dw) cur_col = COORD_BITS'(col + indent * fw);
                else r.status = ST_COL_FULL;
            end else if (code >= lo && code <= hi) begin
                // a glyph needs one spare cell after it
                if (col + 2 * fw <= dw) begin
                    r.action       = ACT_DRAW;
                    r.glyph_offset = OFF_W'((code - lo) * fw * (fh / 8));
                    r.draw_column  = OUTC_W'(col);
                    r.draw_row     = OUTC_W'(row);
                    cur_col        = COORD_BITS'(col + fw);
                end else begin
                    r.status = ST_ROW_FULL;
                end
            end else begin
                r.status = ST_UNSUPPORTED;
            end
            if (byte_count < COUNT_MAX) byte_count++;
            if (r.status != ST_OK) write_held = 1'b1;
        end
        r.bytes_written = byte_count;
        if (is_last) begin
            write_held = 1'b0;
            byte_count = '0;
        end
        return r;
    endfunction

    // Receiver side: random stalls unless running at full rate
    always @(posedge i_clk) begin
        if (full_rate) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (m_axis_tready && $urandom_range(0, 2) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : check_results
        cursor_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cursor_results_due.size() == 0) begin
                $error("result beat with no byte pending: tdata=%h", m_axis_tdata);
                fail_count++;
            end else begin
                want = cursor_results_due.pop_front();
                check_field("action", want.action, m_axis_tdata[1:0]);
                check_field("glyph_offset", want.glyph_offset, m_axis_tdata[17:2]);
                check_field("draw_column", want.draw_column, m_axis_tdata[27:18]);
                check_field("draw_row", want.draw_row, m_axis_tdata[37:28]);
                check_field("status", want.status, m_axis_tdata[40:38]);
                check_field("bytes_written", want.bytes_written, m_axis_tdata[52:41]);
                check_field("tdata padding", 0, m_axis_tdata[55:53]);
                results_checked++;
                if (want.action == ACT_DRAW) draws_seen++;
                if (want.status != ST_OK && want.status != ST_SKIPPED) errors_seen++;
            end
        end
    end

    // Count cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("text_console_cursor_unit_test: FAIL");
        $finish;
    end

    // Send one character beat; a gap may come first
    task automatic send_char(input logic [7:0] code, input logic is_last);
        int gap;
        gap = full_rate ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        cursor_results_due.push_back(console_step(code, is_last));
        chars_sent++;
    endtask

    // Stop sending and wait for every pending result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cursor_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_regs[idx] = val & reg_mask(idx);
    endtask

    task automatic set_console(input logic [CFG_W-1:0] fw, input logic [CFG_W-1:0] fh,
                               input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh,
                               input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                               input logic [CFG_W-1:0] ts);
        drain();
        write_reg(REG_FONT_WIDTH, fw);
        write_reg(REG_FONT_HEIGHT, fh);
        write_reg(REG_DISPLAY_WIDTH, dw);
        write_reg(REG_DISPLAY_HEIGHT, dh);
        write_reg(REG_FIRST_CHAR, lo);
        write_reg(REG_LAST_CHAR, hi);
        write_reg(REG_TAB_SIZE, ts);
        settings_used++;
    endtask

    // Reset values: controls, both ends of the glyph range, an error, skipped bytes, a new write
    task automatic test_reset_defaults();
        send_char(CH_FF, 1'b0);
        send_char(8'h20, 1'b0);
        send_char(8'h7E, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h41, 1'b1);
        send_char(8'h7F, 1'b1);
    endtask

    // Limits of room, font range and register values
    task automatic test_special_cases();
        // tiny display: room for one glyph only, tab and the second line feed run out of room
        set_console(8, 8, 20, 20, 32, 126, 4);
        send_char(CH_FF, 1'b1);
        send_char(8'h41, 1'b1);
        send_char(8'h41, 1'b1);
        send_char(CH_TAB, 1'b1);
        send_char(CH_LF, 1'b1);
        send_char(CH_LF, 1'b1);
        // zero font width and tab size, controls inside a full font range
        set_console(0, 0, 128, 64, 0, 255, 0);
        send_char(CH_TAB, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CH_LF, 1'b1);
        send_char(CH_FF, 1'b1);
        // all bits set: values masked to register width
        set_console(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        send_char(8'hFF, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(8'h41, 1'b1);
        // all zero
        set_console(0, 0, 0, 0, 0, 0, 0);
        send_char(8'h00, 1'b1);
        send_char(CH_TAB, 1'b1);
        // empty font range
        set_console(8, 16, 200, 64, 200, 100, 2);
        send_char(8'h41, 1'b1);
        send_char(8'hC8, 1'b1);
    endtask

    // Random register setting, mostly sensible, sometimes with junk in unused bits
    task automatic randomize_console();
        logic [CFG_W-1:0] v [7];
        int r;
        r    = $urandom_range(0, 9);
        v[0] = CFG_W'((r < 6) ? $urandom_range(4, 12) : (r < 9) ? $urandom_range(1, 32)
                                                                : $urandom_range(0, 63));
        v[1] = CFG_W'(($urandom_range(0, 6) != 0) ? 8 * $urandom_range(1, 8)
                                                   : $urandom_range(0, 127));
        v[2] = CFG_W'(($urandom_range(0, 4) != 0) ? $urandom_range(16, 320)
                                                   : $urandom_range(1, 1023));
        v[3] = CFG_W'(($urandom_range(0, 4) != 0) ? $urandom_range(8, 128)
                                                   : $urandom_range(1, 1023));
        if ($urandom_range(0, 6) != 0) begin
            v[4] = CFG_W'($urandom_range(0, 64));
            v[5] = CFG_W'($urandom_range(v[4] + 16, 255));
        end else begin
            v[4] = CFG_W'($urandom_range(0, 255));
            v[5] = CFG_W'($urandom_range(0, 255));
        end
        v[6] = CFG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                   : $urandom_range(0, 31));
        for (int i = 0; i < 7; i++)
            if ($urandom_range(0, 3) == 0)
                v[i] = v[i] | (CFG_W'($urandom_range(0, 1023)) & ~reg_mask(t_reg_idx'(i)));
        set_console(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
    endtask

    // Byte mix of a well-formed write: half glyphs, with controls and some random bytes
    function automatic logic [7:0] pick_char();
        int r;
        int unsigned lo, hi;
        lo = cfg_regs[REG_FIRST_CHAR];
        hi = cfg_regs[REG_LAST_CHAR];
        r  = $urandom_range(0, 99);
        if (r < 50 && lo <= hi) return 8'($urandom_range(lo, hi));
        if (r < 62) return CH_CR;
        if (r < 74) return CH_LF;
        if (r < 86) return CH_TAB;
        if (r < 91) return CH_FF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Random writes under a series of register settings
    task automatic test_random_writes();
        int sent;
        int len;
        bit noise;
        for (int phase = 0; phase < 8; phase++) begin
            randomize_console();
            full_rate = (phase == 2 || phase == 5);
            sent = 0;
            while (sent < 100) begin
                len   = $urandom_range(1, 24);
                noise = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < len; i++)
                    send_char(noise ? 8'($urandom_range(0, 255)) : pick_char(), i == len - 1);
                sent += len;
            end
        end
        full_rate = 1'b0;
    endtask

    // One long write of carriage returns, then a short one after it
    task automatic test_long_write();
        drain();
        full_rate = 1'b1;
        for (int i = 0; i < LONG_BYTES; i++)
            send_char(CH_CR, i == LONG_BYTES - 1);
        full_rate = 1'b0;
        send_char(CH_CR, 1'b1);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        reset_console();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_random_writes();
        test_long_write();

        drain();
        repeat (4 * COORD_BITS) @(posedge i_clk);
        $display("Checked %0d result beats for %0d bytes under %0d register settings",
                 results_checked, chars_sent, settings_used);
        $display("  %0d glyph draws, %0d error results, one long write of %0d bytes",
                 draws_seen, errors_seen, LONG_BYTES);
        if (fail_count == 0) begin
            $display("text_console_cursor_unit_test: PASS");
        end else begin
            $display("text_console_cursor_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// File: text_console_cursor_unit.f
hdl/tcc_pkg.sv
hdl/tcc_seq.sv
hdl/text_console_cursor_unit.sv
tb/text_console_cursor_unit_test.sv
